@@ rtl/drz_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drz_pkg: shared types and constants
// Image size, fixed-point widths, status and job codes, register indexes.
// ----------------------------------------------------------------------------
package drz_pkg;

    // image grid of the z-buffer
    localparam int COLS        = 512;
    localparam int ROWS        = 424;
    localparam int STORE_DEPTH = ROWS * COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LIM_W       = 13;

    // configuration port
    localparam int CFG_DATA_W = 51;
    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IFOCAL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMITS = 3'd7;
    localparam logic [31:0] LIMITS_RESET = 32'hFFFF_0000;

    // result status codes
    localparam logic [2:0] ST_READ   = 3'd0;
    localparam logic [2:0] ST_STORED = 3'd1;
    localparam logic [2:0] ST_LIMIT  = 3'd2;
    localparam logic [2:0] ST_OOV    = 3'd3;
    localparam logic [2:0] ST_OCCL   = 3'd4;

    // what the back end does with a job
    localparam logic [1:0] KIND_PASS = 2'd0;  // result fully known
    localparam logic [1:0] KIND_READ = 2'd1;  // read entry and clear it
    localparam logic [1:0] KIND_ZBUF = 2'd2;  // depth test and update

    // projection divider: numerator fx*q, denominator qz, clipped quotient
    localparam int NUM_W   = 66;
    localparam int DEN_W   = 24;
    localparam int QUO_W   = 26;
    localparam int HI_W    = NUM_W - QUO_W;
    localparam int DIV_LAT = QUO_W + 1;

    // transformed point width (mm Q.8)
    localparam int Q_W = 41;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        status;
        logic [15:0]       z;
        logic [8:0]        row;
        logic [8:0]        col;
        logic [ADDR_W-1:0] addr;
    } t_job;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] z;
        logic [8:0]  row;
        logic [8:0]  col;
    } t_res;

    typedef struct packed {
        logic       ok;
        logic [8:0] val;
    } t_axis;

    // u = trunc((ratio + c + 0.5 px) / 2^14), checked against the grid size
    function automatic t_axis map_axis(input logic signed [QUO_W:0] q,
                                       input logic ovf,
                                       input logic [23:0] c,
                                       input logic [LIM_W-1:0] lim);
        logic signed [27:0] s;
        t_axis a;
        s = 28'(q) + $signed({4'b0, c}) + 28'sd8192;
        if (!s[27]) begin
            a.ok  = !ovf && (s[26:14] < lim);
            a.val = s[22:14];
        end else begin
            // negative sums above -1.0 truncate to index zero
            a.ok  = !ovf && (s > -28'sd16384);
            a.val = '0;
        end
        return a;
    endfunction

    function automatic logic [ADDR_W-1:0] grid_addr(input logic [8:0] row,
                                                    input logic [8:0] col);
        return ADDR_W'(int'(row) * COLS + int'(col));
    endfunction

endpackage
`default_nettype wire

@@ rtl/drz_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drz_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module drz_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ rtl/drz_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drz_div: pipelined signed divider, quotient truncated toward zero
// One quotient bit per stage; flags quotients too large to land in the image.
// ----------------------------------------------------------------------------
module drz_div import drz_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0]        i_den,
    output logic                         o_ovf,
    output logic signed [QUO_W:0]        o_quo
);
    logic [NUM_W-1:0] w_mag;
    logic [HI_W-1:0]  w_hi;

    logic [DEN_W-1:0] r_rem [QUO_W+1];
    logic [QUO_W-1:0] r_lo  [QUO_W+1];
    logic [QUO_W-1:0] r_quo [QUO_W+1];
    logic [DEN_W-1:0] r_den [QUO_W+1];
    logic             r_neg [QUO_W+1];
    logic             r_ovf [QUO_W+1];

    always_comb begin
        w_mag = i_num[NUM_W-1] ? $unsigned(-i_num) : $unsigned(i_num);
        w_hi  = w_mag[NUM_W-1:QUO_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_hi[DEN_W-1:0];
            r_lo[0]  <= w_mag[QUO_W-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_num[NUM_W-1];
            r_ovf[0] <= (w_hi >= HI_W'(i_den));
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [DEN_W:0] w_t;
        logic [DEN_W:0] w_d;
        logic           w_ge;

        always_comb begin
            w_t  = {r_rem[k-1], r_lo[k-1][QUO_W-1]};
            w_d  = w_t - {1'b0, r_den[k-1]};
            w_ge = (w_t >= {1'b0, r_den[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_d[DEN_W-1:0] : w_t[DEN_W-1:0];
                r_lo[k]  <= {r_lo[k-1][QUO_W-2:0], 1'b0};
                r_quo[k] <= {r_quo[k-1][QUO_W-2:0], w_ge};
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_ovf = r_ovf[QUO_W];
    assign o_quo = r_neg[QUO_W] ? -$signed({1'b0, r_quo[QUO_W]})
                                :  $signed({1'b0, r_quo[QUO_W]});
endmodule
`default_nettype wire

@@ rtl/drz_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drz_front: configuration registers and projection pipeline
// Back-projects, transforms and reprojects each pixel; emits one job per item.
// ----------------------------------------------------------------------------
module drz_front import drz_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_hold,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_mode,
    input  wire logic [8:0]            i_pixel_row,
    input  wire logic [8:0]            i_pixel_col,
    input  wire logic [15:0]           i_depth_mm,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output t_job                       o_job
);
    localparam int DIV_OUT = 7 + DIV_LAT;
    localparam int JOB_ST  = DIV_OUT + 1;

    typedef struct packed {
        logic        mode;
        logic [8:0]  row;
        logic [8:0]  col;
        logic [15:0] depth;
        logic        keep;
        logic        zok;
        logic [15:0] z16;
    } t_meta;

    // configuration
    logic [50:0] r_rot [3];
    logic [50:0] r_trans;
    logic [47:0] r_focal;
    logic [47:0] r_pp;
    logic [47:0] r_ifoc;
    logic [31:0] r_lim;

    logic w_en;
    logic w_acc_in;
    logic r_vld [JOB_ST+1];
    t_meta r_m [DIV_OUT+1];
    t_meta w_m6;

    logic signed [24:0] r_dx, r_dy;
    logic signed [49:0] w_mx, w_my;
    logic signed [35:0] r_rx, r_ry;
    logic signed [52:0] w_prx, w_pry;
    logic signed [36:0] r_px, r_py;
    logic signed [24:0] r_pz;
    logic signed [53:0] r_pr [3][3];
    logic signed [55:0] w_acc [3];
    logic signed [Q_W-1:0] r_q [3];
    logic [44:0]        r_plo [2];
    logic signed [44:0] r_phi [2];
    logic [DEN_W-1:0]   r_den6, r_den7;
    logic signed [NUM_W-1:0] r_n [2];

    logic                    w_ovf_x, w_ovf_y;
    logic signed [QUO_W:0]   w_quo_x, w_quo_y;
    t_axis w_u, w_v;
    t_job  w_job, r_job;

    // pipeline moves as a whole unless the finished job cannot enter the queue
    assign w_en     = !r_vld[JOB_ST] || !i_q_full;
    assign o_stall  = i_hold || !w_en;
    assign w_acc_in = i_valid && !o_stall;
    assign o_push   = r_vld[JOB_ST] && !i_q_full;
    assign o_job    = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= '0;
            r_rot[1] <= '0;
            r_rot[2] <= '0;
            r_trans  <= '0;
            r_focal  <= '0;
            r_pp     <= '0;
            r_ifoc   <= '0;
            r_lim    <= LIMITS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROT0:   r_rot[0] <= i_cfg_data[50:0];
                CFG_ROT1:   r_rot[1] <= i_cfg_data[50:0];
                CFG_ROT2:   r_rot[2] <= i_cfg_data[50:0];
                CFG_TRANS:  r_trans  <= i_cfg_data[50:0];
                CFG_FOCAL:  r_focal  <= i_cfg_data[47:0];
                CFG_PP:     r_pp     <= i_cfg_data[47:0];
                CFG_IFOCAL: r_ifoc   <= i_cfg_data[47:0];
                CFG_LIMITS: r_lim    <= i_cfg_data[31:0];
                default:    r_lim    <= r_lim;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= JOB_ST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= w_acc_in;
            for (int s = 1; s <= JOB_ST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // ray, point and product arithmetic
    always_comb begin
        w_mx  = r_dx * $signed({1'b0, r_ifoc[23:0]});
        w_my  = r_dy * $signed({1'b0, r_ifoc[47:24]});
        w_prx = r_rx * $signed({1'b0, r_m[2].depth});
        w_pry = r_ry * $signed({1'b0, r_m[2].depth});
        for (int i = 0; i < 3; i++) begin
            w_acc[i] = r_pr[i][0] + r_pr[i][1] + r_pr[i][2]
                     + $signed({r_trans[17*i +: 17], 19'b0});
        end
    end

    // z is known once the point is transformed
    always_comb begin
        w_m6     = r_m[5];
        w_m6.zok = !r_q[2][Q_W-1] && (r_q[2] != '0) && (r_q[2][Q_W-1:24] == '0);
        w_m6.z16 = r_q[2][23:8];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m[0].mode  <= i_mode;
            r_m[0].row   <= i_pixel_row;
            r_m[0].col   <= i_pixel_col;
            r_m[0].depth <= i_depth_mm;
            r_m[0].keep  <= (i_depth_mm >= r_lim[15:0]) && (i_depth_mm <= r_lim[31:16]);
            r_m[0].zok   <= 1'b0;
            r_m[0].z16   <= '0;
            for (int s = 1; s <= DIV_OUT; s++) begin
                if (s != 6) begin
                    r_m[s] <= r_m[s-1];
                end
            end
            r_m[6] <= w_m6;

            r_dx <= $signed({2'b00, r_m[0].col, 14'b0}) - $signed({1'b0, r_pp[23:0]});
            r_dy <= $signed({2'b00, r_m[0].row, 14'b0}) - $signed({1'b0, r_pp[47:24]});
            r_rx <= w_mx[49:14];
            r_ry <= w_my[49:14];
            r_px <= w_prx[52:16];
            r_py <= w_pry[52:16];
            r_pz <= $signed({1'b0, r_m[2].depth, 8'b0});
            for (int i = 0; i < 3; i++) begin
                r_pr[i][0] <= $signed(r_rot[i][16:0])  * r_px;
                r_pr[i][1] <= $signed(r_rot[i][33:17]) * r_py;
                r_pr[i][2] <= $signed(r_rot[i][50:34]) * r_pz;
                r_q[i]     <= w_acc[i][55:15];
            end
            // f * q split into two partial products
            r_plo[0] <= r_focal[23:0] * r_q[0][20:0];
            r_plo[1] <= r_focal[47:24] * r_q[1][20:0];
            r_phi[0] <= $signed({1'b0, r_focal[23:0]}) * $signed(r_q[0][Q_W-1:21]);
            r_phi[1] <= $signed({1'b0, r_focal[47:24]}) * $signed(r_q[1][Q_W-1:21]);
            r_den6   <= r_q[2][DEN_W-1:0];
            for (int a = 0; a < 2; a++) begin
                r_n[a] <= $signed({r_phi[a], 21'b0}) + $signed({21'b0, r_plo[a]});
            end
            r_den7 <= r_den6;
            r_job  <= w_job;
        end
    end

    drz_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_n[0]),
        .i_den (r_den7),
        .o_ovf (w_ovf_x),
        .o_quo (w_quo_x)
    );

    drz_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_n[1]),
        .i_den (r_den7),
        .o_ovf (w_ovf_y),
        .o_quo (w_quo_y)
    );

    // classify the item into a job for the back end
    always_comb begin
        w_u = map_axis(w_quo_x, w_ovf_x, r_pp[23:0], LIM_W'(COLS));
        w_v = map_axis(w_quo_y, w_ovf_y, r_pp[47:24], LIM_W'(ROWS));
        w_job.kind   = KIND_PASS;
        w_job.status = ST_READ;
        w_job.z      = '0;
        w_job.row    = '0;
        w_job.col    = '0;
        w_job.addr   = grid_addr(r_m[DIV_OUT].row, r_m[DIV_OUT].col);
        priority if (r_m[DIV_OUT].mode) begin
            if ((LIM_W'(r_m[DIV_OUT].row) < LIM_W'(ROWS))
                && (LIM_W'(r_m[DIV_OUT].col) < LIM_W'(COLS))) begin
                w_job.kind = KIND_READ;
            end
        end else if (!r_m[DIV_OUT].keep) begin
            w_job.status = ST_LIMIT;
        end else if (!r_m[DIV_OUT].zok) begin
            w_job.status = ST_OOV;
        end else if (!(w_u.ok && w_v.ok)) begin
            w_job.status = ST_OOV;
            w_job.z      = r_m[DIV_OUT].z16;
        end else begin
            w_job.kind   = KIND_ZBUF;
            w_job.status = ST_STORED;
            w_job.z      = r_m[DIV_OUT].z16;
            w_job.row    = w_v.val;
            w_job.col    = w_u.val;
            w_job.addr   = grid_addr(w_v.val, w_u.val);
        end
    end
endmodule
`default_nettype wire

@@ rtl/drz_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drz_queue: short job FIFO between front and back
// Register-based, first-word fall-through head.
// ----------------------------------------------------------------------------
module drz_queue import drz_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_head,
    output logic      o_empty
);
    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

@@ rtl/drz_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drz_back: z-buffer store, depth test and result register
// Clears store after reset; then one job per cycle unless stalled; forwarding.
// ----------------------------------------------------------------------------
module drz_back import drz_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    output logic      o_clearing,
    input  wire logic i_q_empty,
    input  t_job      i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_res      o_res
);
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic        r_b1_v;
    t_job        r_b1_job;
    logic        r_fwd_hit;
    logic [15:0] r_fwd_val;
    logic [15:0] w_rdata;
    logic [15:0] w_cur;
    logic        w_b1_done;
    logic        w_b1_ready;
    logic        w_b1_wr;
    logic [15:0] w_b1_wdata;
    t_res        w_res;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [15:0]       w_wdata;

    logic r_out_v;
    t_res r_out;

    assign o_clearing = r_clr_busy;
    assign w_b1_done  = r_b1_v && (!r_out_v || !i_stall);
    assign w_b1_ready = !r_b1_v || w_b1_done;
    assign o_pop      = !i_q_empty && !r_clr_busy && w_b1_ready;
    assign w_cur      = r_fwd_hit ? r_fwd_val : w_rdata;

    always_comb begin
        w_res.status = r_b1_job.status;
        w_res.z      = r_b1_job.z;
        w_res.row    = r_b1_job.row;
        w_res.col    = r_b1_job.col;
        w_b1_wr      = 1'b0;
        w_b1_wdata   = r_b1_job.z;
        unique case (r_b1_job.kind)
            KIND_READ: begin
                w_res.status = ST_READ;
                w_res.z      = w_cur;
                w_b1_wr      = 1'b1;
                w_b1_wdata   = '0;
            end
            KIND_ZBUF: begin
                if ((w_cur == '0) || (r_b1_job.z < w_cur)) begin
                    w_res.status = ST_STORED;
                    w_b1_wr      = 1'b1;
                end else begin
                    w_res.status = ST_OCCL;
                end
            end
            default: begin
                w_b1_wr = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (r_clr_busy) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = w_b1_done && w_b1_wr;
            w_waddr = r_b1_job.addr;
            w_wdata = w_b1_wdata;
        end
    end

    drz_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (o_pop),
        .i_raddr (i_head.addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_b1_v     <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (o_pop) begin
                r_b1_v <= 1'b1;
            end else if (w_b1_done) begin
                r_b1_v <= 1'b0;
            end
            if (w_b1_done) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // the RAM returns old data on a same-cycle write, so catch it here
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_job  <= i_head;
            r_fwd_hit <= w_b1_done && w_b1_wr && (r_b1_job.addr == i_head.addr);
            r_fwd_val <= w_b1_wdata;
        end
        if (w_b1_done) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;
endmodule
`default_nettype wire

@@ rtl/depth_reprojection_zbuffer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// depth_reprojection_zbuffer: depth pixel reprojection into a z-buffer
//
// Input channel (i_valid / o_stall): one item per pixel, mode 0 projects a
// depth pixel, mode 1 reads one z-buffer entry and clears it. Every item
// gives exactly one result on the output channel (o_valid / i_stall), in
// input order, with status, z in mm and the landing row and column.
// Throughput: one item per cycle while o_stall is low. The projection
// pipeline's length is set by the 26-bit pipelined divider that forms the
// projected column and row.
// The z-buffer is a 424 x 512 x 16 RAM with one write and one read port; a
// job reads its entry, tests depth the next cycle and writes back, with a
// same-address write forwarded to the following job.
// Reset: synchronous, active low. After reset a clearing pass writes zero to
// every entry, during which o_stall is high. Configuration writes are taken
// at any time but belong to idle periods.
// When the receiver stalls, the result register holds; a 4-entry job queue
// and the projection pipeline keep taking items until the queue is full and
// a finished job waits at the pipeline's end, then o_stall rises.
// ----------------------------------------------------------------------------
module depth_reprojection_zbuffer import drz_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input items
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_mode,
    input  wire logic [8:0]            i_pixel_row,
    input  wire logic [8:0]            i_pixel_col,
    input  wire logic [15:0]           i_depth_mm,
    // results
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [2:0]                 o_status,
    output logic [15:0]                o_z_value,
    output logic [8:0]                 o_target_row,
    output logic [8:0]                 o_target_col,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic w_clearing;
    logic w_push;
    logic w_q_full;
    logic w_q_empty;
    logic w_pop;
    t_job w_push_job;
    t_job w_head;
    t_res w_res;

    // front: config registers, limit check, projection, classification
    drz_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (w_clearing),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_pixel_row (i_pixel_row),
        .i_pixel_col (i_pixel_col),
        .i_depth_mm  (i_depth_mm),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // decouples the pipeline from the read-modify-write loop
    drz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_q_empty)
    );

    // back: z-buffer RAM, depth test, result register
    drz_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_clearing (w_clearing),
        .i_q_empty  (w_q_empty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (w_res)
    );

    assign o_status     = w_res.status;
    assign o_z_value    = w_res.z;
    assign o_target_row = w_res.row;
    assign o_target_col = w_res.col;

    // no job may enter a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("job pushed into full queue");

    // nothing leaves the queue while the store is being cleared
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> (o_stall && !w_pop))
        else $error("item moved during clearing pass");

    // the clearing pass always follows reset
    a_clear_after_rst: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> w_clearing)
        else $error("clearing pass missing after reset");

    // read results carry no landing place
    a_read_no_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_READ)) |-> (o_target_row == '0 && o_target_col == '0))
        else $error("read result with target fields");
endmodule
`default_nettype wire

@@ tb/tb_depth_reprojection_zbuffer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_reprojection_zbuffer: regression for the depth reprojection z-buffer
// Drives depth pixels and store reads through the valid/stall channels,
// predicts each result with a fixed-point projection model and a z-buffer
// copy, and checks every result in order. Directed corner cases first, then
// random scenes under several camera settings and random back-pressure.
// ----------------------------------------------------------------------------
module tb_depth_reprojection_zbuffer;
    import drz_pkg::*;

    // nominal camera: unit rotation, f = 365 px, centre at (256, 212)
    localparam logic [16:0] UNIT_Q15 = 17'h08000;
    localparam longint NOM_F  = 365 * 16384;
    localparam longint NOM_CX = 256 * 16384;
    localparam longint NOM_CY = 212 * 16384;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_mode = 1'b0;
    logic [8:0]            i_pixel_row = '0;
    logic [8:0]            i_pixel_col = '0;
    logic [15:0]           i_depth_mm = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [2:0]            o_status;
    logic [15:0]           o_z_value;
    logic [8:0]            o_target_row;
    logic [8:0]            o_target_col;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    depth_reprojection_zbuffer u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // camera settings as the block should hold them
    logic [50:0] rot_reg [3];
    logic [50:0] trans_reg;
    logic [47:0] focal_reg, centre_reg, inv_focal_reg;
    logic [31:0] limits_reg;
    logic [15:0] zbuf_copy [STORE_DEPTH];

    t_res        pending_res[$];
    logic [17:0] landed_at[$];     // {row, col} of recent stores, for reads
    int          mismatches = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    bit          hold_req = 1'b0;

    function automatic longint coef(logic [50:0] w, int k);
        return longint'($signed(w[17*k +: 17]));
    endfunction

    function automatic longint rotate_row(int i, longint px, longint py, longint pz);
        longint acc;
        acc = coef(rot_reg[i], 0) * px + coef(rot_reg[i], 1) * py
            + coef(rot_reg[i], 2) * pz + coef(trans_reg, i) * 524288;
        return acc >>> 15;
    endfunction

    // image coordinate, quotient and final shift both truncate toward zero
    function automatic longint image_pos(longint f, longint q, longint qz, longint c);
        longint s;
        s = (f * q) / qz + c + 8192;
        return (s >= 0) ? (s >>> 14) : -((-s) >>> 14);
    endfunction

    // result of one item; updates the z-buffer copy as the block should
    function automatic t_res zbuf_step(logic mode, logic [8:0] row, logic [8:0] col,
                                       logic [15:0] d);
        t_res r;
        longint fx, fy, cx, cy, ifx, ify, rx, ry, px, py, pz, qx, qy, qz, u, v;
        int idx;
        r = '0;
        if (mode) begin
            r.status = ST_READ;
            if (row < ROWS && col < COLS) begin
                idx = int'(row) * COLS + int'(col);
                r.z = zbuf_copy[idx];
                zbuf_copy[idx] = '0;
            end
        end else if (d < limits_reg[15:0] || d > limits_reg[31:16]) begin
            r.status = ST_LIMIT;
        end else begin
            fx  = longint'(focal_reg[23:0]);
            fy  = longint'(focal_reg[47:24]);
            cx  = longint'(centre_reg[23:0]);
            cy  = longint'(centre_reg[47:24]);
            ifx = longint'(inv_focal_reg[23:0]);
            ify = longint'(inv_focal_reg[47:24]);
            rx  = ((longint'(col) * 16384 - cx) * ifx) >>> 14;
            ry  = ((longint'(row) * 16384 - cy) * ify) >>> 14;
            px  = (rx * longint'(d)) >>> 16;
            py  = (ry * longint'(d)) >>> 16;
            pz  = longint'(d) * 256;
            qx  = rotate_row(0, px, py, pz);
            qy  = rotate_row(1, px, py, pz);
            qz  = rotate_row(2, px, py, pz);
            if (qz <= 0 || qz >= 64'sd16777216) begin
                r.status = ST_OOV;
            end else begin
                r.z = 16'(qz >>> 8);
                u = image_pos(fx, qx, qz, cx);
                v = image_pos(fy, qy, qz, cy);
                if (u >= 0 && u < COLS && v >= 0 && v < ROWS) begin
                    idx = int'(v) * COLS + int'(u);
                    r.row = 9'(v);
                    r.col = 9'(u);
                    if (zbuf_copy[idx] == 0 || r.z < zbuf_copy[idx]) begin
                        zbuf_copy[idx] = r.z;   // a zero z leaves the entry empty
                        r.status = ST_STORED;
                        landed_at.push_back({r.row, r.col});
                        if (landed_at.size() > 64) void'(landed_at.pop_front());
                    end else begin
                        r.status = ST_OCCL;
                    end
                end else begin
                    r.status = ST_OOV;
                    r.row = '0;
                    r.col = '0;
                end
            end
        end
        return r;
    endfunction

    // ---- drivers -----------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_valid     <= 1'b0;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_ROT0:   rot_reg[0]    = val[50:0];
            CFG_ROT1:   rot_reg[1]    = val[50:0];
            CFG_ROT2:   rot_reg[2]    = val[50:0];
            CFG_TRANS:  trans_reg     = val[50:0];
            CFG_FOCAL:  focal_reg     = val[47:0];
            CFG_PP:     centre_reg    = val[47:0];
            CFG_IFOCAL: inv_focal_reg = val[47:0];
            CFG_LIMITS: limits_reg    = val[31:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one item on the input channel; predicts its result when taken
    task automatic send_pixel(logic mode, logic [8:0] row, logic [8:0] col,
                              logic [15:0] d);
        @(negedge i_clk);
        while (!tx_calm && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_pixel_row <= row;
        i_pixel_col <= col;
        i_depth_mm  <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_res.push_back(zbuf_step(mode, row, col, d));
    endtask

    // sender goes quiet until every result is back
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending_res.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_camera(logic [50:0] r0, logic [50:0] r1, logic [50:0] r2,
                              logic [50:0] t, longint fx, longint fy,
                              longint cx, longint cy, logic [31:0] lim);
        write_reg(CFG_ROT0, r0);
        write_reg(CFG_ROT1, r1);
        write_reg(CFG_ROT2, r2);
        write_reg(CFG_TRANS, t);
        write_reg(CFG_FOCAL, {24'(fy), 24'(fx)});
        write_reg(CFG_PP, {24'(cy), 24'(cx)});
        write_reg(CFG_IFOCAL, {24'((64'd1 << 38) / fy), 24'((64'd1 << 38) / fx)});
        write_reg(CFG_LIMITS, lim);
    endtask

    task automatic nominal_camera(logic [50:0] t, logic [31:0] lim);
        set_camera({34'd0, UNIT_Q15}, {17'd0, UNIT_Q15, 17'd0}, {UNIT_Q15, 34'd0},
                   t, NOM_F, NOM_F, NOM_CX, NOM_CY, lim);
    endtask

    task automatic read_last_landing;
        logic [17:0] a;
        a = (landed_at.size() > 0) ? landed_at[$] : 18'd0;
        send_pixel(1'b1, a[17:9], a[8:0], 16'($urandom));
    endtask

    // ---- result checker ----------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d z %0d row %0d col %0d",
                             o_status, o_z_value, o_target_row, o_target_col);
            end else begin
                want = pending_res.pop_front();
                if (o_status !== want.status || o_z_value !== want.z ||
                    o_target_row !== want.row || o_target_col !== want.col) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: want st %0d z %0d r %0d c %0d, ",
                                  "got st %0d z %0d r %0d c %0d"},
                                 want.status, want.z, want.row, want.col,
                                 o_status, o_z_value, o_target_row, o_target_col);
                end
            end
        end
    end

    // receiver: random stall, calm stretches, one long hold-off on request
    always @(negedge i_clk) begin
        int hold_left;
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 7);
        end
    end

    // ---- tests -------------------------------------------------------------
    // settings as after reset: every projection collapses to z = 0
    task automatic test_reset_settings;
        send_pixel(1'b0, 9'd0, 9'd0, 16'd0);
        send_pixel(1'b0, 9'd423, 9'd511, 16'hFFFF);
        send_pixel(1'b1, 9'd0, 9'd0, 16'd0);
        send_pixel(1'b1, 9'd423, 9'd511, 16'hFFFF);
        drain();
    endtask

    task automatic test_directed_zbuffer;
        nominal_camera('0, 32'hFFFF_0000);
        send_pixel(1'b0, 9'd100, 9'd200, 16'd1000);
        send_pixel(1'b0, 9'd100, 9'd200, 16'd1500);     // farther: occluded
        send_pixel(1'b0, 9'd100, 9'd200, 16'd800);      // nearer: replaces
        read_last_landing();
        read_last_landing();                            // cleared by the read
        send_pixel(1'b1, 9'd500, 9'd511, 16'd0);        // read beyond the grid
        send_pixel(1'b1, 9'd423, 9'd511, 16'd0);
        send_pixel(1'b0, 9'd0, 9'd0, 16'd0);            // z zero: out of view
        send_pixel(1'b0, 9'd423, 9'd511, 16'hFFFF);
        send_pixel(1'b0, 9'd212, 9'd256, 16'hFFFF);
        drain();
        // depth window 500..3000
        write_reg(CFG_LIMITS, {16'd3000, 16'd500});
        send_pixel(1'b0, 9'd50, 9'd60, 16'd499);
        send_pixel(1'b0, 9'd50, 9'd60, 16'd500);
        send_pixel(1'b0, 9'd51, 9'd60, 16'd3000);
        send_pixel(1'b0, 9'd52, 9'd60, 16'd3001);
        drain();
        // tz of -1/16 mm: z truncates to zero, reported stored, entry stays empty
        write_reg(CFG_LIMITS, 32'hFFFF_0000);
        write_reg(CFG_TRANS, {17'h1FFFF, 34'd0});
        send_pixel(1'b0, 9'd212, 9'd256, 16'd1);
        read_last_landing();
        drain();
        // tz of +1 mm: deepest pixel lands past the far end of z
        write_reg(CFG_TRANS, {17'h00010, 34'd0});
        send_pixel(1'b0, 9'd212, 9'd256, 16'hFFFF);
        drain();
        // large x shift: lands beside the image
        write_reg(CFG_TRANS, {34'd0, 17'h0FFFF});
        send_pixel(1'b0, 9'd212, 9'd256, 16'd500);
        drain();
        // every register bit set
        set_camera('1, '1, '1, '1, 64'hFFFFFF, 64'hFFFFFF, 64'hFFFFFF, 64'hFFFFFF,
                   32'hFFFF_FFFF);
        write_reg(CFG_IFOCAL, '1);
        send_pixel(1'b0, 9'd423, 9'd511, 16'hFFFF);
        send_pixel(1'b0, 9'd0, 9'd0, 16'hFFFF);
        drain();
    endtask

    // scenes of pixels in a small window, reads of landed entries, and noise
    task automatic random_items(int n, int r0, int c0);
        int r, c, pick;
        logic [17:0] a;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            r = r0 + $urandom_range(12) - 6;
            c = c0 + $urandom_range(12) - 6;
            r = (r < 0) ? 0 : (r > ROWS - 1) ? ROWS - 1 : r;
            c = (c < 0) ? 0 : (c > COLS - 1) ? COLS - 1 : c;
            if (pick < 55) begin
                send_pixel(1'b0, 9'(r), 9'(c), 16'($urandom_range(4500, 400)));
            end else if (pick < 80) begin
                if (landed_at.size() > 0 && $urandom_range(9) < 8)
                    a = landed_at[$urandom_range(landed_at.size() - 1)];
                else
                    a = {9'(r), 9'(c)};
                send_pixel(1'b1, a[17:9], a[8:0], 16'($urandom));
            end else if (pick < 90) begin
                send_pixel(1'b0, 9'($urandom_range(ROWS - 1)), 9'($urandom),
                           16'($urandom));
            end else begin
                send_pixel(1'b1, 9'($urandom), 9'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic random_camera;
        logic [16:0] k [9];
        logic [16:0] t [3];
        longint fx, fy;
        for (int i = 0; i < 9; i++)
            k[i] = (i % 4 == 0) ? 17'(32768 + int'($urandom_range(4000)) - 2000)
                                : 17'(int'($urandom_range(6000)) - 3000);
        t[0] = 17'(int'($urandom_range(6400)) - 3200);
        t[1] = 17'(int'($urandom_range(6400)) - 3200);
        t[2] = 17'(int'($urandom_range(16000)) - 8000);
        fx = longint'($urandom_range(500 * 16384, 300 * 16384));
        fy = longint'($urandom_range(500 * 16384, 300 * 16384));
        set_camera({k[2], k[1], k[0]}, {k[5], k[4], k[3]}, {k[8], k[7], k[6]},
                   {t[2], t[1], t[0]}, fx, fy,
                   longint'($urandom_range(276 * 16384, 236 * 16384)),
                   longint'($urandom_range(232 * 16384, 192 * 16384)),
                   ($urandom_range(3) == 0) ?
                       {16'($urandom_range(65535, 2000)), 16'($urandom_range(1500))}
                       : 32'hFFFF_0000);
    endtask

    task automatic test_random_scenes(int n_phases);
        for (int p = 0; p < n_phases; p++) begin
            drain();
            if (p == 0)
                nominal_camera('0, 32'hFFFF_0000);
            else if (p == 5)
                set_camera(51'({$urandom, $urandom}), 51'({$urandom, $urandom}),
                           51'({$urandom, $urandom}), 51'({$urandom, $urandom}),
                           longint'($urandom), longint'($urandom),
                           longint'($urandom), longint'($urandom), $urandom);
            else
                random_camera();
            tx_calm = (p == 3);
            rx_calm = (p == 3);
            random_items(150, $urandom_range(ROWS - 1), $urandom_range(COLS - 1));
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        drain();
    endtask

    // receiver holds off long enough that the block fills and stalls its input
    task automatic test_backpressure;
        nominal_camera('0, 32'hFFFF_0000);
        hold_req = 1'b1;
        tx_calm  = 1'b1;
        random_items(120, 212, 256);
        tx_calm  = 1'b0;
        drain();
        random_items(40, 100, 100);
        drain();
    endtask

    initial begin
        rot_reg[0]    = '0;
        rot_reg[1]    = '0;
        rot_reg[2]    = '0;
        trans_reg     = '0;
        focal_reg     = '0;
        centre_reg    = '0;
        inv_focal_reg = '0;
        limits_reg    = LIMITS_RESET;
        for (int i = 0; i < STORE_DEPTH; i++) zbuf_copy[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_settings();
        test_directed_zbuffer();
        test_random_scenes(10);
        test_backpressure();

        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && pending_res.size() == 0)
            $display("depth_reprojection_zbuffer regression: pass");
        else
            $display("depth_reprojection_zbuffer regression: fail");
        $finish;
    end

    // covers the clearing pass after reset with a wide margin
    initial begin
        #30ms;
        $display("depth_reprojection_zbuffer regression: fail");
        $finish;
    end

endmodule

@@ depth_reprojection_zbuffer.f @@
rtl/drz_pkg.sv
rtl/drz_ram.sv
rtl/drz_div.sv
rtl/drz_front.sv
rtl/drz_queue.sv
rtl/drz_back.sv
rtl/depth_reprojection_zbuffer.sv
tb/tb_depth_reprojection_zbuffer.sv
